FILE: rtl/type_length_package_splitter_defines.svh
// Assertion macros used by the splitter parser.
`ifndef TYPE_LENGTH_PACKAGE_SPLITTER_DEFINES_SVH
`define TYPE_LENGTH_PACKAGE_SPLITTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TLPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define TLPS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tlps_pkg.sv
// Types and constants of the type-length package splitter.
`default_nettype none

package tlps_pkg;

   localparam int TYPE_BYTES   = 4;
   localparam int LEN_BYTES    = 4;
   localparam int BUFFER_BYTES = 65536;

   localparam int HDR_COUNT_W = 3;
   localparam logic [15:0] AFTER_MAX = 16'(BUFFER_BYTES - 1);

   typedef enum logic [1:0] {
      PHASE_TYPE    = 2'd0,
      PHASE_LEN     = 2'd1,
      PHASE_CONTENT = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  stream_id;
      logic [7:0]  data_byte;
      logic [15:0] bytes_after;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_stream_id;
      logic        is_header;
      logic [31:0] package_type;
      logic [15:0] content_length;
      logic [7:0]  content_byte;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } parse_result_type;

endpackage

`default_nettype wire

FILE: rtl/tlps_input_stage.sv
// Input register of the splitter.
`default_nettype none

module tlps_input_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tlps_pkg::req_item_type req_item,
   input  wire logic                  advance,
   output logic                       stage_valid,
   output tlps_pkg::req_item_type     stage_item
);
   import tlps_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // Take a new item when the register is empty or its item moves on.
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

`default_nettype wire

FILE: rtl/tlps_parser.sv
// Header and content tracking of the splitter, one byte per step.
`default_nettype none
`include "type_length_package_splitter_defines.svh"

module tlps_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire tlps_pkg::req_item_type  item,
   output tlps_pkg::parse_result_type  result
);
   import tlps_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [HDR_COUNT_W-1:0] hbc_ff, hbc_in;
   logic [31:0]            type_ff, type_in;
   logic [31:0]            len_ff, len_in;
   logic [15:0]            content_left_ff, content_left_in;
   logic                   dropping_ff, dropping_in;

   logic [15:0]            after_sat;
   logic [4:0]             shift_amt;
   logic [31:0]            byte_shifted;
   logic [HDR_COUNT_W-1:0] hbc_inc;
   logic                   type_done;
   logic                   len_done;
   logic [31:0]            len_or;
   logic                   len_fits;
   logic                   len_zero;
   logic [15:0]            cl_dec;
   logic                   cl_zero;
   logic                   buf_end;

   assign after_sat    = (item.bytes_after > AFTER_MAX) ? AFTER_MAX : item.bytes_after;
   assign shift_amt    = {hbc_ff[1:0], 3'b000};
   assign byte_shifted = {24'b0, item.data_byte} << shift_amt;
   assign hbc_inc      = hbc_ff + HDR_COUNT_W'(1);
   assign type_done    = hbc_inc >= HDR_COUNT_W'(TYPE_BYTES);
   assign len_done     = hbc_inc >= HDR_COUNT_W'(LEN_BYTES);
   assign len_or       = len_ff | byte_shifted;
   assign len_fits     = len_or <= {16'b0, after_sat};
   assign len_zero     = len_or == 32'b0;
   assign cl_dec       = content_left_ff - 16'd1;
   assign cl_zero      = cl_dec == 16'b0;
   assign buf_end      = after_sat == 16'b0;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (!dropping_ff) begin
         case (phase_ff)
            PHASE_CONTENT: begin
               if (cl_zero) begin
                  phase_in = PHASE_TYPE;
               end
            end
            PHASE_LEN: begin
               if (len_done && len_fits) begin
                  phase_in = len_zero ? PHASE_TYPE : PHASE_CONTENT;
               end
            end
            default: begin
               phase_in = type_done ? PHASE_LEN : PHASE_TYPE;
            end
         endcase
      end
      if (buf_end) begin
         phase_in = PHASE_TYPE;
      end
   end

   // Accumulators and result.
   always_comb begin
      hbc_in          = hbc_ff;
      type_in         = type_ff;
      len_in          = len_ff;
      content_left_in = content_left_ff;
      dropping_in     = dropping_ff;
      result          = '0;
      result.item.out_stream_id = item.stream_id;
      if (!dropping_ff) begin
         case (phase_ff)
            PHASE_CONTENT: begin
               content_left_in          = cl_dec;
               result.emit              = 1'b1;
               result.item.content_byte = item.data_byte;
               result.item.last         = cl_zero || buf_end;
               if (cl_zero) begin
                  hbc_in  = '0;
                  type_in = '0;
                  len_in  = '0;
               end
            end
            PHASE_LEN: begin
               len_in = len_or;
               hbc_in = hbc_inc;
               if (len_done) begin
                  if (len_fits) begin
                     result.emit                = 1'b1;
                     result.item.is_header      = 1'b1;
                     result.item.package_type   = type_ff;
                     result.item.content_length = len_or[15:0];
                     result.item.last           = len_zero;
                     if (len_zero) begin
                        type_in = '0;
                     end else begin
                        content_left_in = len_or[15:0];
                     end
                  end else begin
                     dropping_in = 1'b1;
                  end
                  hbc_in = '0;
                  len_in = '0;
               end
            end
            default: begin
               type_in = type_ff | byte_shifted;
               hbc_in  = hbc_inc;
               if (type_done) begin
                  hbc_in = '0;
                  len_in = '0;
               end
            end
         endcase
      end
      // Buffer end: start the next buffer afresh.
      if (buf_end) begin
         hbc_in          = '0;
         type_in         = '0;
         len_in          = '0;
         content_left_in = '0;
         dropping_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_TYPE;
         hbc_ff          <= '0;
         type_ff         <= '0;
         len_ff          <= '0;
         content_left_ff <= '0;
         dropping_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         hbc_ff          <= hbc_in;
         type_ff         <= type_in;
         len_ff          <= len_in;
         content_left_ff <= content_left_in;
         dropping_ff     <= dropping_in;
      end
   end

   `TLPS_ASSERT_IMPL(a_drop_silent, dropping_ff, !result.emit, "result while dropping")
   `TLPS_ASSERT_IMPL(a_content_left, phase_ff == PHASE_CONTENT, content_left_ff != 16'b0, "content phase with nothing left")
   `TLPS_ASSERT_IMPL(a_type_count, phase_ff == PHASE_TYPE, hbc_ff < HDR_COUNT_W'(TYPE_BYTES), "type byte count overrun")
   `TLPS_ASSERT_IMPL(a_empty_header, result.emit && result.item.is_header && result.item.last, result.item.content_length == 16'b0, "empty package header with length")

endmodule

`default_nettype wire

FILE: rtl/tlps_output_stage.sv
// Result register of the splitter.
`default_nettype none

module tlps_output_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      stage_valid,
   input  wire tlps_pkg::parse_result_type result,
   output logic                           advance,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output tlps_pkg::rsp_item_type         rsp_item
);
   import tlps_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   logic         emit;

   // Move on when the register is empty or its item is taken.
   assign advance  = !valid_ff || !rsp_stall;
   assign emit     = stage_valid && result.emit;
   assign valid_in = advance ? emit : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         item_ff <= result.item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

FILE: rtl/type_length_package_splitter.sv
// Top level of the type-length package splitter.
`default_nettype none

// Splits received buffers into packages of a 4-byte type, a 4-byte length (both
// little-endian) and that many content bytes. Feed one buffer byte per item with
// the count of bytes that follow it; a count of zero ends the buffer and resets
// parsing. A complete header whose content fits in the buffer gives one header
// item, then one item per content byte with the final one marked last; a short
// header gives nothing, and content that does not fit drops the rest of the
// buffer. The block takes one byte per cycle while its result is not stalled;
// each byte passes through the input register, then through the parse logic
// into the result register. A stalled result holds the pipeline, and the input
// side stalls only when both registers are full.
module type_length_package_splitter (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire tlps_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output tlps_pkg::rsp_item_type      rsp_item
);
   import tlps_pkg::*;

   logic             advance;
   logic             stage_valid;
   req_item_type     stage_item;
   parse_result_type result;
   logic             fire;

   assign fire = stage_valid && advance;

   tlps_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   tlps_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (stage_item),
      .result (result)
   );

   tlps_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire
